// ----- src/assert_macros.svh -----
// Assertion macros shared by the sequencer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(name, clk, rstn, cond) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
    else $error("invariant violated");

// A condition that must hold in the same cycle as its trigger.
`define ASSERT_SAME(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// A condition that must hold in the cycle after its trigger.
`define ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

// ----- src/sls_pkg.sv -----
package sls_pkg;

  localparam int unsigned StepW = 29;
  localparam int unsigned DevEnW = 16;
  localparam int unsigned CfgDataW = 29;
  localparam int unsigned CfgIndexW = 2;

  localparam logic [CfgIndexW-1:0] CfgSyncStep = 2'd0;
  localparam logic [CfgIndexW-1:0] CfgDevEnable = 2'd1;
  localparam logic [CfgIndexW-1:0] CfgLoopPresent = 2'd2;

  localparam logic [StepW-1:0] SyncStepReset = 29'd559240;
  localparam logic [DevEnW-1:0] DevEnableReset = 16'd1;

  localparam logic [1:0] ActCmd = 2'd0;
  localparam logic [1:0] ActTick = 2'd1;
  localparam logic [1:0] ActSeek = 2'd2;

  localparam logic [7:0] CmdWaitOne = 8'hff;
  localparam logic [7:0] CmdWaitN = 8'hfe;
  localparam logic [7:0] CmdLoop = 8'hfd;

  typedef enum logic [2:0] {
    EvNone  = 3'd0,
    EvWrite = 3'd1,
    EvLoop  = 3'd2,
    EvEnd   = 3'd3,
    EvSync  = 3'd4
  } event_e;

  typedef struct packed {
    logic [StepW-1:0]  sync_step;
    logic [DevEnW-1:0] device_enable;
    logic              loop_present;
  } cfg_t;

  typedef struct packed {
    event_e      event_res;
    logic [3:0]  device_index;
    logic [8:0]  reg_address;
    logic [7:0]  reg_value;
    logic        want_bytes;
    logic [31:0] sync_time;
  } result_t;

endpackage

// ----- src/sls_cfg.sv -----
module sls_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sls_pkg::CfgIndexW-1:0]  cfg_index_i,
  input  logic [sls_pkg::CfgDataW-1:0]   cfg_data_i,
  output sls_pkg::cfg_t                  cfg_o
);

  sls_pkg::cfg_t cfg_q;
  sls_pkg::cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        sls_pkg::CfgSyncStep: begin
          cfg_d.sync_step = cfg_data_i[sls_pkg::StepW-1:0];
        end
        sls_pkg::CfgDevEnable: begin
          cfg_d.device_enable = cfg_data_i[sls_pkg::DevEnW-1:0];
        end
        sls_pkg::CfgLoopPresent: begin
          cfg_d.loop_present = cfg_data_i[0];
        end
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_step <= sls_pkg::SyncStepReset;
      cfg_q.device_enable <= sls_pkg::DevEnableReset;
      cfg_q.loop_present <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- src/sls_in_reg.sv -----
module sls_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] action_i,
  input  logic [7:0] cmd_byte_i,
  input  logic       out_free_i,
  output logic       fire_o,
  output logic [1:0] action_o,
  output logic [7:0] cmd_byte_o
);

  logic       valid_q;
  logic       valid_d;
  logic [1:0] action_q;
  logic [7:0] cmd_byte_q;
  logic       load;

  assign in_stall_o = valid_q && !out_free_i;
  assign fire_o = valid_q && out_free_i;
  assign load = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (fire_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      action_q <= action_i;
      cmd_byte_q <= cmd_byte_i;
    end
  end

  assign action_o = action_q;
  assign cmd_byte_o = cmd_byte_q;

endmodule

// ----- src/sls_engine.sv -----
`include "assert_macros.svh"

module sls_engine #(
  parameter int unsigned MAX_DEVICES = 16,
  parameter int unsigned PHASE_BITS = 28
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic [1:0]       action_i,
  input  logic [7:0]       cmd_byte_i,
  input  sls_pkg::cfg_t    cfg_i,
  output sls_pkg::result_t res_o
);

  localparam logic [1:0] PhOpcode = 2'd0;
  localparam logic [1:0] PhReg = 2'd1;
  localparam logic [1:0] PhValue = 2'd2;
  localparam logic [1:0] PhVarint = 2'd3;
  localparam logic [2:0] VarintDigits = 3'd4;
  localparam int unsigned CmpW =
    (PHASE_BITS + 1 > sls_pkg::StepW) ? PHASE_BITS + 1 : sls_pkg::StepW;

  logic [1:0]            phase_q, phase_d;
  logic [6:0]            opcode_q, opcode_d;
  logic [7:0]            reg_q, reg_d;
  logic [27:0]           varint_q, varint_d;
  logic [2:0]            digits_q, digits_d;
  logic [31:0]           wait_q, wait_d;
  logic [PHASE_BITS-1:0] sample_q, sample_d;
  logic [31:0]           elapsed_q, elapsed_d;
  logic                  ended_q, ended_d;

  logic [27:0]           varint_part;
  logic [27:0]           varint_eff;
  logic [28:0]           wait_add;
  logic [32:0]           wait_sum;
  logic [31:0]           wait_sat;
  logic [31:0]           wait_dec;
  logic [31:0]           elapsed_inc;
  logic [CmpW-1:0]       step_ext;
  logic [CmpW-1:0]       limit;
  logic [CmpW-1:0]       step_clamp;
  logic [PHASE_BITS:0]   phase_sum;
  logic [5:0]            dev;
  logic                  dev_ok;
  sls_pkg::result_t      res;

  always_comb begin
    varint_part = '0;
    case (digits_q)
      3'd0: varint_part[6:0] = cmd_byte_i[6:0];
      3'd1: varint_part[13:7] = cmd_byte_i[6:0];
      3'd2: varint_part[20:14] = cmd_byte_i[6:0];
      3'd3: varint_part[27:21] = cmd_byte_i[6:0];
      default: varint_part = '0;
    endcase
  end

  assign varint_eff = varint_q | varint_part;
  assign wait_add = (phase_q == PhOpcode) ? 29'd1 : ({1'b0, varint_eff} + 29'd2);
  assign wait_sum = {1'b0, wait_q} + {4'b0, wait_add};
  assign wait_sat = wait_sum[32] ? 32'hffff_ffff : wait_sum[31:0];
  assign wait_dec = (wait_q != 32'd0) ? wait_q - 32'd1 : wait_q;
  assign elapsed_inc = (elapsed_q != 32'hffff_ffff) ? elapsed_q + 32'd1 : elapsed_q;

  assign step_ext = CmpW'(cfg_i.sync_step);
  assign limit = CmpW'(1) << PHASE_BITS;
  assign step_clamp = (step_ext > limit) ? limit : step_ext;
  assign phase_sum = {1'b0, sample_q} + step_clamp[PHASE_BITS:0];

  assign dev = opcode_q[6:1];
  assign dev_ok = (dev < 6'(MAX_DEVICES)) && (dev[5:4] == 2'b00)
                  && cfg_i.device_enable[dev[3:0]];

  always_comb begin
    phase_d = phase_q;
    opcode_d = opcode_q;
    reg_d = reg_q;
    varint_d = varint_q;
    digits_d = digits_q;
    wait_d = wait_q;
    sample_d = sample_q;
    elapsed_d = elapsed_q;
    ended_d = ended_q;
    res = '0;
    res.event_res = sls_pkg::EvNone;
    case (action_i)
      sls_pkg::ActCmd: begin
        if (!ended_q) begin
          case (phase_q)
            PhOpcode: begin
              if (!cmd_byte_i[7]) begin
                opcode_d = cmd_byte_i[6:0];
                phase_d = PhReg;
              end else if (cmd_byte_i == sls_pkg::CmdWaitOne) begin
                wait_d = wait_sat;
              end else if (cmd_byte_i == sls_pkg::CmdWaitN) begin
                varint_d = '0;
                digits_d = '0;
                phase_d = PhVarint;
              end else if (cmd_byte_i == sls_pkg::CmdLoop && cfg_i.loop_present) begin
                res.event_res = sls_pkg::EvLoop;
              end else begin
                ended_d = 1'b1;
                wait_d = '0;
                res.event_res = sls_pkg::EvEnd;
              end
            end
            PhReg: begin
              reg_d = cmd_byte_i;
              phase_d = PhValue;
            end
            PhValue: begin
              if (dev_ok) begin
                res.event_res = sls_pkg::EvWrite;
                res.device_index = dev[3:0];
                res.reg_address = {opcode_q[0], reg_q};
                res.reg_value = cmd_byte_i;
              end
              phase_d = PhOpcode;
            end
            default: begin
              if (digits_q < VarintDigits) begin
                varint_d = varint_eff;
                digits_d = digits_q + 3'd1;
              end
              if (!cmd_byte_i[7]) begin
                wait_d = wait_sat;
                phase_d = PhOpcode;
              end
            end
          endcase
        end
      end
      sls_pkg::ActTick: begin
        if (wait_q != 32'd0) begin
          sample_d = phase_sum[PHASE_BITS-1:0];
          if (phase_sum[PHASE_BITS]) begin
            wait_d = wait_dec;
            elapsed_d = elapsed_inc;
            res.event_res = sls_pkg::EvSync;
          end
        end
      end
      sls_pkg::ActSeek: begin
        elapsed_d = elapsed_inc;
        wait_d = wait_dec;
        res.event_res = sls_pkg::EvSync;
      end
      default: begin
        res.event_res = sls_pkg::EvNone;
      end
    endcase
    res.want_bytes = (wait_d == 32'd0) && !ended_d;
    res.sync_time = elapsed_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhOpcode;
      opcode_q <= '0;
      reg_q <= '0;
      varint_q <= '0;
      digits_q <= '0;
      wait_q <= '0;
      sample_q <= '0;
      elapsed_q <= '0;
      ended_q <= 1'b0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      opcode_q <= opcode_d;
      reg_q <= reg_d;
      varint_q <= varint_d;
      digits_q <= digits_d;
      wait_q <= wait_d;
      sample_q <= sample_d;
      elapsed_q <= elapsed_d;
      ended_q <= ended_d;
    end
  end

  assign res_o = res;

  `ASSERT_SAME(a_ended_no_wait, clk_i, rst_ni, ended_q, wait_q == 32'd0)
  `ASSERT_SAME(a_ended_at_opcode, clk_i, rst_ni, ended_q, phase_q == PhOpcode)
  `ASSERT_NEXT(a_ended_sticky, clk_i, rst_ni, ended_q, ended_q)
  `ASSERT_ALWAYS(a_digits_range, clk_i, rst_ni, digits_q <= VarintDigits)

endmodule

// ----- src/sls_out_reg.sv -----
module sls_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  sls_pkg::result_t res_i,
  input  logic             out_stall_i,
  output logic             out_free_o,
  output logic             out_valid_o,
  output sls_pkg::result_t res_o
);

  logic             valid_q;
  logic             valid_d;
  sls_pkg::result_t res_q;

  assign out_free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (fire_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o = res_q;

endmodule

// ----- src/sound_log_command_sequencer.sv -----
// Channel   Direction  Handshake              Payload
// input     in         in_valid_i/in_stall_o  action_i, cmd_byte_i
// result    out        out_valid_o/out_stall_i event_res_o .. sync_time_o
// config    in         cfg_we_i               cfg_index_i, cfg_data_i
//
// Each request yields one result, passed through the input and then the result register.
// A new request is taken every cycle unless a stalled result holds it; the rate is set
// by the single input register and result register around the parse and phase logic.
// Reset clears all sequencer state and loads the register defaults.
// A stalled result holds the result register, which then holds the input register.
`include "assert_macros.svh"

module sound_log_command_sequencer #(
  parameter int unsigned MAX_DEVICES = 16,
  parameter int unsigned PHASE_BITS = 28
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    action_i,
  input  logic [7:0]                    cmd_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [2:0]                    event_res_o,
  output logic [3:0]                    device_index_o,
  output logic [8:0]                    reg_address_o,
  output logic [7:0]                    reg_value_o,
  output logic                          want_bytes_o,
  output logic [31:0]                   sync_time_o,
  input  logic                          cfg_we_i,
  input  logic [sls_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [sls_pkg::CfgDataW-1:0]  cfg_data_i
);

  sls_pkg::cfg_t    cfg;
  sls_pkg::result_t res_comb;
  sls_pkg::result_t res_out;
  logic             fire;
  logic             out_free;
  logic [1:0]       action_r;
  logic [7:0]       cmd_byte_r;

  sls_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  sls_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .action_i   (action_i),
    .cmd_byte_i (cmd_byte_i),
    .out_free_i (out_free),
    .fire_o     (fire),
    .action_o   (action_r),
    .cmd_byte_o (cmd_byte_r)
  );

  sls_engine #(
    .MAX_DEVICES (MAX_DEVICES),
    .PHASE_BITS  (PHASE_BITS)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .action_i   (action_r),
    .cmd_byte_i (cmd_byte_r),
    .cfg_i      (cfg),
    .res_o      (res_comb)
  );

  sls_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .res_i       (res_comb),
    .out_stall_i (out_stall_i),
    .out_free_o  (out_free),
    .out_valid_o (out_valid_o),
    .res_o       (res_out)
  );

  assign event_res_o = res_out.event_res;
  assign device_index_o = res_out.device_index;
  assign reg_address_o = res_out.reg_address;
  assign reg_value_o = res_out.reg_value;
  assign want_bytes_o = res_out.want_bytes;
  assign sync_time_o = res_out.sync_time;

  `ASSERT_SAME(a_stall_only_when_full, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)

endmodule

// ----- tb/sound_log_command_sequencer_tb.sv -----
`timescale 1ns / 1ps

module sound_log_command_sequencer_tb;

  typedef enum logic [1:0] {
    ParseOpcode = 2'd0,
    ParseRegister = 2'd1,
    ParseValue = 2'd2,
    ParseVarint = 2'd3
  } parse_e;

  localparam logic [1:0] ActNop = 2'd3;
  localparam logic [7:0] CmdWriteLimit = 8'h80;
  localparam logic [7:0] CmdFirstUnknown = 8'h80;
  localparam logic [7:0] CmdLastUnknown = 8'hfc;
  localparam int unsigned MaxDevices = 16;
  localparam int unsigned VarintBits = 28;
  localparam logic [29:0] PhaseOne = 30'h1000_0000;
  localparam logic [sls_pkg::StepW-1:0] StepMax = '1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] action_i = sls_pkg::ActCmd;
  logic [7:0] cmd_byte_i = 8'h00;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [2:0] event_res_o;
  logic [3:0] device_index_o;
  logic [8:0] reg_address_o;
  logic [7:0] reg_value_o;
  logic want_bytes_o;
  logic [31:0] sync_time_o;
  logic cfg_we_i = 1'b0;
  logic [sls_pkg::CfgIndexW-1:0] cfg_index_i = sls_pkg::CfgSyncStep;
  logic [sls_pkg::CfgDataW-1:0] cfg_data_i = '0;

  logic [sls_pkg::StepW-1:0] step_cfg = sls_pkg::SyncStepReset;
  logic [sls_pkg::DevEnW-1:0] dev_cfg = sls_pkg::DevEnableReset;
  logic loop_cfg = 1'b0;

  parse_e cur_parse = ParseOpcode;
  logic [6:0] cur_opcode = '0;
  logic [7:0] cur_register = '0;
  logic [27:0] cur_varint = '0;
  logic [4:0] cur_shift = '0;
  logic [31:0] cur_wait = '0;
  logic [28:0] cur_phase = '0;
  logic [31:0] cur_elapsed = '0;
  logic cur_ended = 1'b0;

  sls_pkg::result_t pending_results[$];
  int unsigned mismatches = 0;
  int unsigned requests_sent = 0;
  int unsigned hold_cycles = 0;
  int unsigned stall_left = 0;
  bit no_idle = 1'b0;

  sound_log_command_sequencer DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .action_i(action_i),
    .cmd_byte_i(cmd_byte_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .event_res_o(event_res_o),
    .device_index_o(device_index_o),
    .reg_address_o(reg_address_o),
    .reg_value_o(reg_value_o),
    .want_bytes_o(want_bytes_o),
    .sync_time_o(sync_time_o),
    .cfg_we_i(cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [32:0] n);
    logic [33:0] s;
    s = {2'b00, a} + {1'b0, n};
    return (s > 34'h0_ffff_ffff) ? 32'hffff_ffff : s[31:0];
  endfunction

  function automatic sls_pkg::result_t play_request(input logic [1:0] act, input logic [7:0] b);
    sls_pkg::result_t r;
    logic [5:0] dev;
    logic [29:0] inc;
    logic [29:0] acc;
    r = '0;
    r.event_res = sls_pkg::EvNone;
    if (act == sls_pkg::ActCmd && !cur_ended) begin
      case (cur_parse)
        ParseOpcode: begin
          if (b < CmdWriteLimit) begin
            cur_opcode = b[6:0];
            cur_parse = ParseRegister;
          end else if (b == sls_pkg::CmdWaitOne) begin
            cur_wait = add_sat(cur_wait, 33'd1);
          end else if (b == sls_pkg::CmdWaitN) begin
            cur_varint = '0;
            cur_shift = '0;
            cur_parse = ParseVarint;
          end else if (b == sls_pkg::CmdLoop && loop_cfg) begin
            r.event_res = sls_pkg::EvLoop;
          end else begin
            cur_ended = 1'b1;
            cur_wait = '0;
            cur_parse = ParseOpcode;
            r.event_res = sls_pkg::EvEnd;
          end
        end
        ParseRegister: begin
          cur_register = b;
          cur_parse = ParseValue;
        end
        ParseValue: begin
          dev = cur_opcode[6:1];
          if (dev < MaxDevices && dev_cfg[dev[3:0]]) begin
            r.event_res = sls_pkg::EvWrite;
            r.device_index = dev[3:0];
            r.reg_address = {cur_opcode[0], cur_register};
            r.reg_value = b;
          end
          cur_parse = ParseOpcode;
        end
        default: begin
          if (cur_shift < VarintBits) begin
            cur_varint = cur_varint | (28'(b[6:0]) << cur_shift);
            cur_shift = (cur_shift + 5'd7 > VarintBits) ? 5'(VarintBits) : cur_shift + 5'd7;
          end
          if (!b[7]) begin
            cur_wait = add_sat(cur_wait, {5'b0, cur_varint} + 33'd2);
            cur_parse = ParseOpcode;
          end
        end
      endcase
    end else if (act == sls_pkg::ActTick) begin
      if (cur_wait != 0) begin
        inc = (30'(step_cfg) > PhaseOne) ? PhaseOne : 30'(step_cfg);
        acc = 30'(cur_phase) + inc;
        if (acc >= PhaseOne) begin
          acc = acc - PhaseOne;
          cur_wait = cur_wait - 32'd1;
          cur_elapsed = add_sat(cur_elapsed, 33'd1);
          r.event_res = sls_pkg::EvSync;
        end
        cur_phase = acc[28:0];
      end
    end else if (act == sls_pkg::ActSeek) begin
      cur_elapsed = add_sat(cur_elapsed, 33'd1);
      if (cur_wait != 0) cur_wait = cur_wait - 32'd1;
      r.event_res = sls_pkg::EvSync;
    end
    r.want_bytes = (cur_wait == 0) && !cur_ended;
    r.sync_time = cur_elapsed;
    return r;
  endfunction

  function automatic void check_field(input string name, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    sls_pkg::result_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) pending_results.push_back(play_request(action_i, cmd_byte_i));
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none actual event %0h", $time,
                   event_res_o);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("event_res", want.event_res, event_res_o);
          check_field("device_index", want.device_index, device_index_o);
          check_field("reg_address", want.reg_address, reg_address_o);
          check_field("reg_value", want.reg_value, reg_value_o);
          check_field("want_bytes", want.want_bytes, want_bytes_o);
          check_field("sync_time", want.sync_time, sync_time_o);
        end
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_cycles != 0) begin
        stall_left = hold_cycles;
        hold_cycles = 0;
      end else if (stall_left == 0 && !no_idle && $urandom_range(0, 99) < 15) begin
        stall_left = pick_gap();
      end
      out_stall_i <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  task automatic send_request(input logic [1:0] act, input logic [7:0] b);
    int unsigned gap;
    in_valid_i <= 1'b1;
    action_i <= act;
    cmd_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    requests_sent++;
    gap = no_idle ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic [sls_pkg::StepW-1:0] step,
                                input logic [sls_pkg::DevEnW-1:0] devs,
                                input logic loop);
    wait_for_results();
    cfg_we_i <= 1'b1;
    cfg_index_i <= sls_pkg::CfgSyncStep;
    cfg_data_i <= sls_pkg::CfgDataW'(step);
    @(posedge clk_i);
    cfg_index_i <= sls_pkg::CfgDevEnable;
    cfg_data_i <= sls_pkg::CfgDataW'(devs);
    @(posedge clk_i);
    cfg_index_i <= sls_pkg::CfgLoopPresent;
    cfg_data_i <= sls_pkg::CfgDataW'(loop);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    step_cfg = step;
    dev_cfg = devs;
    loop_cfg = loop;
  endtask

  task automatic maybe_interject();
    if ($urandom_range(0, 99) < 5)
      send_request($urandom_range(0, 1) ? sls_pkg::ActTick : ActNop, 8'($urandom));
  endtask

  task automatic send_random_command();
    int unsigned r;
    int unsigned len;
    int unsigned i;
    logic [7:0] b;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      b = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 31)) : 8'($urandom_range(32, 127));
      send_request(sls_pkg::ActCmd, b);
      maybe_interject();
      send_request(sls_pkg::ActCmd, 8'($urandom));
      maybe_interject();
      send_request(sls_pkg::ActCmd, 8'($urandom));
    end else if (r < 70) begin
      send_request(sls_pkg::ActCmd, sls_pkg::CmdWaitOne);
    end else if (r < 90) begin
      send_request(sls_pkg::ActCmd, sls_pkg::CmdWaitN);
      r = $urandom_range(0, 99);
      len = (r < 80) ? 1 : ((r < 95) ? $urandom_range(2, 3) : $urandom_range(4, 7));
      for (i = 1; i <= len; i++) begin
        b = ($urandom_range(0, 99) < 95) ? 8'($urandom_range(0, 3)) : 8'($urandom);
        b[7] = (i != len);
        maybe_interject();
        send_request(sls_pkg::ActCmd, b);
      end
    end else begin
      send_request(sls_pkg::ActCmd, loop_cfg ? sls_pkg::CmdLoop : sls_pkg::CmdWaitOne);
    end
  endtask

  task automatic send_random_item();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) send_random_command();
    else if (r < 48) repeat ($urandom_range(5, 40)) send_request(sls_pkg::ActTick, 8'($urandom));
    else if (r < 75) send_request(sls_pkg::ActTick, 8'($urandom));
    else if (r < 92) send_request(sls_pkg::ActSeek, 8'($urandom));
    else send_request(ActNop, 8'($urandom));
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned stop;
    stop = requests_sent + count;
    while (requests_sent < stop) begin
      no_idle = ((requests_sent / 60) % 4) == 3;
      send_random_item();
    end
    no_idle = 1'b0;
  endtask

  task automatic test_directed();
    send_request(sls_pkg::ActTick, 8'h00);
    send_request(sls_pkg::ActCmd, 8'h00);
    send_request(sls_pkg::ActCmd, 8'h00);
    send_request(sls_pkg::ActCmd, 8'h00);
    send_request(sls_pkg::ActCmd, 8'h01);
    send_request(sls_pkg::ActCmd, 8'hff);
    send_request(sls_pkg::ActCmd, 8'hff);
    send_request(sls_pkg::ActCmd, 8'h02);
    send_request(sls_pkg::ActCmd, 8'h12);
    send_request(sls_pkg::ActCmd, 8'h34);
    send_request(sls_pkg::ActCmd, 8'h7f);
    send_request(sls_pkg::ActCmd, 8'haa);
    send_request(sls_pkg::ActCmd, 8'h55);
    send_request(sls_pkg::ActCmd, sls_pkg::CmdWaitOne);
    send_request(ActNop, 8'hff);
    send_request(sls_pkg::ActTick, 8'h00);
    send_request(sls_pkg::ActSeek, 8'h00);
    send_request(sls_pkg::ActCmd, sls_pkg::CmdWaitN);
    send_request(sls_pkg::ActCmd, 8'h00);
    send_request(sls_pkg::ActCmd, sls_pkg::CmdWaitN);
    repeat (5) send_request(sls_pkg::ActCmd, 8'hff);
    send_request(sls_pkg::ActCmd, 8'h7f);
    send_request(sls_pkg::ActSeek, 8'hff);
  endtask

  task automatic test_config_extremes();
    apply_settings(StepMax, 16'hffff, 1'b1);
    send_request(sls_pkg::ActCmd, sls_pkg::CmdLoop);
    send_request(sls_pkg::ActCmd, 8'h1f);
    send_request(sls_pkg::ActCmd, 8'h80);
    send_request(sls_pkg::ActCmd, 8'h01);
    repeat (3) send_request(sls_pkg::ActTick, 8'h00);
    send_request(sls_pkg::ActSeek, 8'h00);
    apply_settings('0, 16'h0000, 1'b1);
    send_request(sls_pkg::ActCmd, 8'h1e);
    send_request(sls_pkg::ActCmd, 8'h01);
    send_request(sls_pkg::ActCmd, 8'h02);
    send_request(sls_pkg::ActTick, 8'h00);
    send_request(sls_pkg::ActSeek, 8'h00);
  endtask

  task automatic test_result_hold();
    int unsigned i;
    no_idle = 1'b1;
    hold_cycles = 100;
    for (i = 0; i < 40; i++) send_random_item();
    no_idle = 1'b0;
  endtask

  task automatic test_sender_pause();
    run_random(30);
    wait_for_results();
    run_random(30);
  endtask

  task automatic test_random_settings();
    apply_settings(sls_pkg::StepW'(PhaseOne), 16'hffff, 1'b1);
    run_random(150);
    test_result_hold();
    test_sender_pause();
    run_random(150);
    apply_settings(sls_pkg::StepW'($urandom_range(32'h0800_0000, 32'h0fff_ffff)),
                   16'($urandom), 1'b0);
    run_random(200);
    apply_settings('0, 16'h0000, 1'b1);
    run_random(200);
    apply_settings(StepMax, 16'h8001, 1'b0);
    run_random(300);
    apply_settings(sls_pkg::StepW'(1), 16'($urandom), 1'b1);
    run_random(200);
    apply_settings(sls_pkg::StepW'($urandom), 16'hffff, 1'($urandom));
    run_random(150);
  endtask

  task automatic test_wait_saturation();
    repeat (17) begin
      send_request(sls_pkg::ActCmd, sls_pkg::CmdWaitN);
      repeat (3) send_request(sls_pkg::ActCmd, 8'hff);
      send_request(sls_pkg::ActCmd, 8'h7f);
    end
    send_request(sls_pkg::ActSeek, 8'h00);
    send_request(sls_pkg::ActTick, 8'h00);
  endtask

  task automatic test_song_end();
    apply_settings(sls_pkg::StepW'(PhaseOne), 16'hffff, 1'b0);
    send_request(sls_pkg::ActCmd, sls_pkg::CmdLoop);
    send_request(sls_pkg::ActCmd, sls_pkg::CmdWaitOne);
    send_request(sls_pkg::ActCmd, sls_pkg::CmdWaitN);
    send_request(sls_pkg::ActCmd, 8'h00);
    send_request(sls_pkg::ActCmd, 8'($urandom_range(CmdFirstUnknown, CmdLastUnknown)));
    repeat (12) send_request(2'($urandom), 8'($urandom));
    send_request(sls_pkg::ActSeek, 8'h00);
    send_request(sls_pkg::ActTick, 8'h00);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_extremes();
    test_random_settings();
    test_wait_saturation();
    test_song_end();
    wait_for_results();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
